>>> hw/rtl/wavhp_pkg.sv
// Shared types and constants for the WAV header parser.
// Holds parser phases, the per-byte event record, and the port payload structs.
// No dependencies.
`timescale 1ns / 1ps

package wavhp_pkg;

    // Chunk tags as they read little-endian from four bytes
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Minimum fmt body length in bytes
    localparam logic [31:0] FMT_BODY = 32'd16;

    // Format the data chunk requires
    localparam logic [15:0] REQ_CHANNELS = 16'd1;
    localparam logic [15:0] REQ_BITS     = 16'd16;

    // Reset value of the expected sample rate
    localparam logic [31:0] RATE_RESET = 32'd16000;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_WAV = 2'd1;
    localparam logic [1:0] ST_BAD_FMT = 2'd2;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_CHUNK,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_DONE
    } phase_t;

    // One input byte request
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } byte_item_t;

    // One result request
    typedef struct packed {
        logic              kind;
        logic signed [15:0] sample;
        logic [1:0]        status;
        logic              last;
    } result_t;

    // Everything one byte produced: an optional sample, then an optional status
    typedef struct packed {
        logic              has_sample;
        logic signed [15:0] sample;
        logic              has_status;
        logic [1:0]        status;
        logic              last;
    } event_t;

endpackage

>>> hw/rtl/wavhp_parser.sv
// Front end of the WAV header parser: consumes one file byte per accepted request,
// tracks RIFF/chunk state and produces an event record for the result queue.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  wavhp_pkg::byte_item_t   byte_item,
    input  logic [31:0]             expected_rate,
    output logic                    ev_push,
    output wavhp_pkg::event_t       ev
);

    wavhp_pkg::phase_t phase_reg, phase_next, phase_mid;

    logic [3:0]  byte_count_reg, byte_count_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] bytes_remaining_reg, bytes_remaining_next;
    logic [15:0] channel_count_reg, channel_count_next;
    logic [31:0] declared_rate_reg, declared_rate_next;
    logic [15:0] bits_per_sample_reg, bits_per_sample_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic        low_byte_held_reg, low_byte_held_next;
    logic        header_ok_reg, header_ok_next;

    logic [7:0]  b;
    logic        eof;
    logic [31:0] tag_sh;
    logic [31:0] len_sh;
    logic [32:0] skip_chunk_sum;
    logic [31:0] skip_chunk_cnt;
    logic [31:0] skip_fmt_cnt;
    logic [31:0] skip_cnt;
    logic        st_valid;
    logic [1:0]  st_code;
    logic        smp_valid;

    assign b   = byte_item.file_byte;
    assign eof = byte_item.end_of_file;

    // Shift the new byte in at the top (little-endian word assembly)
    assign tag_sh = {b, chunk_tag_reg[31:8]};
    assign len_sh = {b, chunk_length_reg[31:8]};

    // Skip lengths: chunk body plus pad byte, saturated; or fmt tail plus pad byte
    assign skip_chunk_sum = {1'b0, len_sh} + {32'd0, len_sh[0]};
    assign skip_chunk_cnt = skip_chunk_sum[32] ? 32'hFFFF_FFFF : skip_chunk_sum[31:0];
    assign skip_fmt_cnt   = chunk_length_reg - (chunk_length_reg[0] ? 32'd15 : 32'd16);
    assign skip_cnt       = (phase_reg == wavhp_pkg::PH_FMT) ? skip_fmt_cnt : skip_chunk_cnt;

    // Classify the byte and work out the next datapath values
    always_comb
    begin
        byte_count_next      = byte_count_reg;
        chunk_tag_next       = chunk_tag_reg;
        chunk_length_next    = chunk_length_reg;
        bytes_remaining_next = bytes_remaining_reg;
        channel_count_next   = channel_count_reg;
        declared_rate_next   = declared_rate_reg;
        bits_per_sample_next = bits_per_sample_reg;
        low_byte_next        = low_byte_reg;
        low_byte_held_next   = low_byte_held_reg;
        header_ok_next       = header_ok_reg;
        phase_mid            = phase_reg;
        st_valid             = 1'b0;
        st_code              = wavhp_pkg::ST_OK;
        smp_valid            = 1'b0;

        unique case (phase_reg)
            wavhp_pkg::PH_RIFF:
            begin
                chunk_tag_next = tag_sh;
                if (byte_count_reg == 4'd3 && tag_sh != wavhp_pkg::TAG_RIFF)
                begin
                    header_ok_next = 1'b0;
                end
                if (byte_count_reg >= 4'd11)
                begin
                    if (tag_sh != wavhp_pkg::TAG_WAVE)
                    begin
                        header_ok_next = 1'b0;
                    end
                    byte_count_next = 4'd0;
                    if (!header_ok_next)
                    begin
                        st_valid = 1'b1;
                        st_code  = wavhp_pkg::ST_NOT_WAV;
                    end
                    else
                    begin
                        phase_mid = wavhp_pkg::PH_CHUNK;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end

            wavhp_pkg::PH_CHUNK:
            begin
                if (byte_count_reg < 4'd4)
                begin
                    chunk_tag_next = tag_sh;
                end
                else
                begin
                    chunk_length_next = len_sh;
                end
                if (byte_count_reg >= 4'd7)
                begin
                    byte_count_next = 4'd0;
                    if (chunk_tag_reg == wavhp_pkg::TAG_FMT)
                    begin
                        if (len_sh < wavhp_pkg::FMT_BODY)
                        begin
                            st_valid = 1'b1;
                            st_code  = wavhp_pkg::ST_BAD_FMT;
                        end
                        else
                        begin
                            phase_mid = wavhp_pkg::PH_FMT;
                        end
                    end
                    else if (chunk_tag_reg == wavhp_pkg::TAG_DATA)
                    begin
                        if (len_sh == 32'd0
                            || channel_count_reg != wavhp_pkg::REQ_CHANNELS
                            || declared_rate_reg != expected_rate
                            || bits_per_sample_reg != wavhp_pkg::REQ_BITS)
                        begin
                            st_valid = 1'b1;
                            st_code  = wavhp_pkg::ST_BAD_FMT;
                        end
                        else
                        begin
                            bytes_remaining_next = len_sh;
                            low_byte_held_next   = 1'b0;
                            phase_mid            = wavhp_pkg::PH_DATA;
                        end
                    end
                    else if (skip_cnt == 32'd0)
                    begin
                        phase_mid = wavhp_pkg::PH_CHUNK;
                    end
                    else
                    begin
                        bytes_remaining_next = skip_cnt;
                        phase_mid            = wavhp_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end

            wavhp_pkg::PH_FMT:
            begin
                if (byte_count_reg == 4'd2)
                begin
                    channel_count_next = {8'd0, b};
                end
                else if (byte_count_reg == 4'd3)
                begin
                    channel_count_next = {b, channel_count_reg[7:0]};
                end
                else if (byte_count_reg >= 4'd4 && byte_count_reg <= 4'd7)
                begin
                    declared_rate_next = {b, declared_rate_reg[31:8]};
                end
                else if (byte_count_reg == 4'd14)
                begin
                    bits_per_sample_next = {8'd0, b};
                end
                else if (byte_count_reg == 4'd15)
                begin
                    bits_per_sample_next = {b, bits_per_sample_reg[7:0]};
                end

                if (byte_count_reg == 4'd15)
                begin
                    byte_count_next = 4'd0;
                    if (skip_cnt == 32'd0)
                    begin
                        phase_mid = wavhp_pkg::PH_CHUNK;
                    end
                    else
                    begin
                        bytes_remaining_next = skip_cnt;
                        phase_mid            = wavhp_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end

            wavhp_pkg::PH_SKIP:
            begin
                bytes_remaining_next = bytes_remaining_reg - 32'd1;
                if (bytes_remaining_reg == 32'd1)
                begin
                    byte_count_next = 4'd0;
                    phase_mid       = wavhp_pkg::PH_CHUNK;
                end
            end

            wavhp_pkg::PH_DATA:
            begin
                if (low_byte_held_reg)
                begin
                    smp_valid          = 1'b1;
                    low_byte_held_next = 1'b0;
                end
                else
                begin
                    low_byte_next      = b;
                    low_byte_held_next = 1'b1;
                end
                bytes_remaining_next = bytes_remaining_reg - 32'd1;
                if (bytes_remaining_reg == 32'd1)
                begin
                    st_valid = 1'b1;
                    st_code  = wavhp_pkg::ST_OK;
                end
            end

            wavhp_pkg::PH_DONE:
            begin
                // Ignore bytes until the file ends
            end

            default:
            begin
            end
        endcase

        // Close the file with a status if nothing else did
        if (!st_valid && eof && phase_reg != wavhp_pkg::PH_DONE)
        begin
            st_valid = 1'b1;
            if (phase_mid == wavhp_pkg::PH_RIFF)
            begin
                st_code = wavhp_pkg::ST_NOT_WAV;
            end
            else if (phase_mid == wavhp_pkg::PH_DATA)
            begin
                st_code = wavhp_pkg::ST_OK;
            end
            else
            begin
                st_code = wavhp_pkg::ST_BAD_FMT;
            end
        end

        // Clear everything at the end of a file
        if (eof)
        begin
            byte_count_next      = 4'd0;
            chunk_tag_next       = 32'd0;
            chunk_length_next    = 32'd0;
            bytes_remaining_next = 32'd0;
            channel_count_next   = 16'd0;
            declared_rate_next   = 32'd0;
            bits_per_sample_next = 16'd0;
            low_byte_next        = 8'd0;
            low_byte_held_next   = 1'b0;
            header_ok_next       = 1'b1;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (eof)
            begin
                phase_next = wavhp_pkg::PH_RIFF;
            end
            else if (st_valid)
            begin
                phase_next = wavhp_pkg::PH_DONE;
            end
            else
            begin
                phase_next = phase_mid;
            end
        end
    end

    // Build the event record for the result queue
    always_comb
    begin
        ev_push       = accept && (smp_valid || st_valid);
        ev.has_sample = smp_valid;
        ev.sample     = $signed({b, low_byte_reg});
        ev.has_status = st_valid;
        ev.status     = st_code;
        ev.last       = eof;
    end

    // Hold parser state, advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= wavhp_pkg::PH_RIFF;
            byte_count_reg      <= 4'd0;
            chunk_tag_reg       <= 32'd0;
            chunk_length_reg    <= 32'd0;
            bytes_remaining_reg <= 32'd0;
            channel_count_reg   <= 16'd0;
            declared_rate_reg   <= 32'd0;
            bits_per_sample_reg <= 16'd0;
            low_byte_reg        <= 8'd0;
            low_byte_held_reg   <= 1'b0;
            header_ok_reg       <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            if (accept)
            begin
                byte_count_reg      <= byte_count_next;
                chunk_tag_reg       <= chunk_tag_next;
                chunk_length_reg    <= chunk_length_next;
                bytes_remaining_reg <= bytes_remaining_next;
                channel_count_reg   <= channel_count_next;
                declared_rate_reg   <= declared_rate_next;
                bits_per_sample_reg <= bits_per_sample_next;
                low_byte_reg        <= low_byte_next;
                low_byte_held_reg   <= low_byte_held_next;
                header_ok_reg       <= header_ok_next;
            end
        end
    end

endmodule

>>> hw/rtl/wavhp_fifo.sv
// Short event queue between the parser front end and the result back end.
// Register array with a fill count; depth set by the DEPTH parameter (2 or more).
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  wavhp_pkg::event_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output wavhp_pkg::event_t rd_data,
    output logic              empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wavhp_pkg::event_t store [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store[rd_ptr_reg];

    // Advance pointers with wrap, track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/wavhp_emit.sv
// Back end of the WAV header parser: splits each event into its sample and status
// results and presents them one at a time from an output register.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_emit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ev_valid,
    input  wavhp_pkg::event_t  ev,
    output logic               ev_take,
    input  logic               pop,
    output logic               empty,
    output wavhp_pkg::result_t result
);

    logic                cur_valid_reg, cur_valid_next;
    wavhp_pkg::result_t  cur_reg, cur_next;
    logic                pend_valid_reg, pend_valid_next;
    wavhp_pkg::result_t  pend_reg, pend_next;
    wavhp_pkg::result_t  smp_res;
    wavhp_pkg::result_t  st_res;
    logic                slot_free;

    assign empty  = !cur_valid_reg;
    assign result = cur_reg;

    // Output slot frees when empty or when the current result is taken
    assign slot_free = !cur_valid_reg || pop;

    // Format the two possible results of an event
    always_comb
    begin
        smp_res.kind   = wavhp_pkg::KIND_SAMPLE;
        smp_res.sample = ev.sample;
        smp_res.status = wavhp_pkg::ST_OK;
        smp_res.last   = 1'b0;
        st_res.kind    = wavhp_pkg::KIND_STATUS;
        st_res.sample  = 16'sd0;
        st_res.status  = ev.status;
        st_res.last    = ev.last;
    end

    // Refill the output slot: pending status first, then a fresh event
    always_comb
    begin
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        ev_take         = 1'b0;
        if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                cur_next        = pend_reg;
                cur_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (ev_valid)
            begin
                ev_take        = 1'b1;
                cur_valid_next = 1'b1;
                if (ev.has_sample)
                begin
                    cur_next        = smp_res;
                    pend_next       = st_res;
                    pend_valid_next = ev.has_status;
                end
                else
                begin
                    cur_next = st_res;
                end
            end
            else
            begin
                cur_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

endmodule

>>> hw/rtl/wav_header_parser.sv
// WAV header parser top level: byte queue in, result queue out.
// A byte's result is written into the event queue, then moved into the output register once that is free.
// Throughput: one byte per cycle while the event queue is not full; the last data byte yields a sample
// and a status, which leave the output register one after the other (the single result port).
// Reset: rst_n clears the parser to the RIFF header phase, empties the event queue
// and output, and sets expected_rate to 16000. Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wav_header_parser
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  wavhp_pkg::byte_item_t   byte_item,
    input  logic                    pop,
    output logic                    empty,
    output wavhp_pkg::result_t      result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             cfg_data
);

    logic [31:0]       expected_rate_reg;
    logic              accept;
    logic              ev_push;
    wavhp_pkg::event_t ev_in;
    wavhp_pkg::event_t ev_out;
    logic              ev_empty;
    logic              ev_take;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    // Hold the expected rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rate_reg <= wavhp_pkg::RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            expected_rate_reg <= cfg_data;
        end
    end

    wavhp_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_item     (byte_item),
        .expected_rate (expected_rate_reg),
        .ev_push       (ev_push),
        .ev            (ev_in)
    );

    wavhp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_push),
        .wr_data (ev_in),
        .full    (full),
        .rd_en   (ev_take),
        .rd_data (ev_out),
        .empty   (ev_empty)
    );

    wavhp_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (!ev_empty),
        .ev       (ev_out),
        .ev_take  (ev_take),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule
